### rtl/core/ssba_pkg.sv
// Package with the constants, codes and shared types of the swap slot bitmap allocator.
`timescale 1ns / 1ps

package ssba_pkg;

    // Sizing of the slot space and of one slot.
    localparam int MAX_SLOTS        = 1024;
    localparam int SECTORS_PER_SLOT = 8;

    // Field widths of the channels and of the register.
    localparam int CFG_W        = 11;
    localparam int CFG_RESET    = 1024;
    localparam int CMD_W        = 2;
    localparam int SLOT_FIELD_W = 10;
    localparam int STATUS_W     = 2;
    localparam int SECTOR_W     = 13;
    localparam int OFFSET_W     = 12;
    localparam int SECTOR_BYTES = 512;

    // Bitmap geometry: power-of-two words, one row per word.
    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int WORD_W = ((2 ** SLOT_W) < 32) ? (2 ** SLOT_W) : 32;
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int ROW_W  = (SLOT_W > BIT_W) ? (SLOT_W - BIT_W) : 1;
    localparam int ROWS   = 2 ** ROW_W;
    localparam int IDX_W  = ROW_W + BIT_W;

    // Width that holds any slot count, both the register and MAX_SLOTS.
    localparam int CNT_W  = ($clog2(MAX_SLOTS + 1) > CFG_W) ? $clog2(MAX_SLOTS + 1) : CFG_W;

    // Sector index counter inside one slot.
    localparam int SIDX_W = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_STORE = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_FREE  = 2'd2
    } cmd_t;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_CHECK,
        S_OUT
    } state_t;

    // Request from the sequencer to the bitmap store.
    typedef struct packed {
        logic [ROW_W-1:0]  rd_row;
        logic              wr_en;
        logic [ROW_W-1:0]  wr_row;
        logic [WORD_W-1:0] wr_data;
    } bm_req_t;

endpackage

### rtl/core/ssba_cmd_if.sv
// Command channel interface: valid, ready and the command payload.
`timescale 1ns / 1ps

interface ssba_cmd_if;
    import ssba_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [SLOT_FIELD_W-1:0] slot_index;

    modport source (output valid, output cmd, output slot_index, input ready);
    modport sink   (input valid, input cmd, input slot_index, output ready);
endinterface

### rtl/core/ssba_res_if.sv
// Result channel interface: valid, ready and the result payload.
`timescale 1ns / 1ps

interface ssba_res_if;
    import ssba_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [SLOT_FIELD_W-1:0] slot_out;
    logic [SECTOR_W-1:0]     sector_number;
    logic [OFFSET_W-1:0]     page_offset;
    logic                    transfer_valid;
    logic                    last;

    modport source (output valid, output status, output slot_out, output sector_number,
                    output page_offset, output transfer_valid, output last, input ready);
    modport sink   (input valid, input status, input slot_out, input sector_number,
                    input page_offset, input transfer_valid, input last, output ready);
endinterface

### rtl/core/ssba_bitmap.sv
// Occupancy bitmap store: one word per row, registered read, per-row valid bits.
`timescale 1ns / 1ps

module ssba_bitmap (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ssba_pkg::bm_req_t         req,
    output logic [ssba_pkg::WORD_W-1:0] rd_word
);
    import ssba_pkg::*;

    logic [WORD_W-1:0] mem [ROWS];
    logic [ROWS-1:0]   row_valid_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_row] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_row];
    end

    // A row that was never written reads as all free, which stands in for the reset clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                row_valid_reg[req.wr_row] <= 1'b1;
            end
            rd_valid_reg <= row_valid_reg[req.rd_row];
        end
    end

    assign rd_word = rd_valid_reg ? rd_data_reg : '0;

endmodule

### rtl/core/ssba_zero_find.sv
// Finds the lowest clear bit of one bitmap word.
`timescale 1ns / 1ps

module ssba_zero_find (
    input  logic [ssba_pkg::WORD_W-1:0] word,
    output logic                        found,
    output logic [ssba_pkg::BIT_W-1:0]  idx
);
    import ssba_pkg::*;

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                found = 1'b1;
                idx   = BIT_W'(i);
            end
        end
    end

endmodule

### rtl/core/swap_slot_bitmap_allocator.sv
// Top level of the swap slot bitmap allocator: command sequencer and result register.
`timescale 1ns / 1ps

// The block keeps one occupancy bit per swap slot in a bitmap of 32 words of 32 bits and
// handles one command at a time; command.ready is high only while it is idle. A store is
// accepted and then scans the bitmap one word per cycle through a single lowest-zero finder
// up to the first free slot (at most 32 words, fewer when slot_count is small); it then gives
// eight results on success, one when no slot is free. A load reads and checks its bitmap
// word and then gives eight results, a free-only command one. Each result is held while
// result.ready is low. No clearing pass follows reset: per-word valid bits make unwritten
// words read as free. An unused command code is accepted and dropped without a result.
// slot_count is written through cfg_wr_en and cfg_wr_data; the user must write it only while
// the block is idle, and the block itself does not enforce it.
module swap_slot_bitmap_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [ssba_pkg::CFG_W-1:0] cfg_wr_data,
    ssba_cmd_if.sink                   command,
    ssba_res_if.source                 result
);
    import ssba_pkg::*;

    state_t                  state_reg, state_next;
    logic [CFG_W-1:0]        slot_count_reg;
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [SLOT_FIELD_W-1:0] slot_in_reg, slot_in_next;
    logic [ROW_W-1:0]        row_reg, row_next;

    logic [STATUS_W-1:0]     stat_reg, stat_next;
    logic [SLOT_FIELD_W-1:0] slot_out_reg, slot_out_next;
    logic [SECTOR_W-1:0]     sector_reg, sector_next;
    logic [OFFSET_W-1:0]     offset_reg, offset_next;
    logic                    xfer_reg, xfer_next;
    logic                    last_reg, last_next;
    logic [SIDX_W-1:0]       sidx_reg, sidx_next;

    bm_req_t                 bm_req;
    logic [WORD_W-1:0]       rd_word;
    logic                    zf_found;
    logic [BIT_W-1:0]        zf_idx;

    logic [CNT_W-1:0]        eff_count;
    logic [CNT_W-1:0]        cfg_ext;

    ssba_bitmap u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (bm_req),
        .rd_word (rd_word)
    );

    ssba_zero_find u_zero_find (
        .word  (rd_word),
        .found (zf_found),
        .idx   (zf_idx)
    );

    assign cfg_ext   = CNT_W'(slot_count_reg);
    assign eff_count = (cfg_ext < CNT_W'(MAX_SLOTS)) ? cfg_ext : CNT_W'(MAX_SLOTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_count_reg <= CFG_W'(CFG_RESET);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                slot_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        slot_in_reg  <= slot_in_next;
        row_reg      <= row_next;
        stat_reg     <= stat_next;
        slot_out_reg <= slot_out_next;
        sector_reg   <= sector_next;
        offset_reg   <= offset_next;
        xfer_reg     <= xfer_next;
        last_reg     <= last_next;
        sidx_reg     <= sidx_next;
    end

    always_comb
    begin
        logic [IDX_W+SLOT_FIELD_W-1:0] in_wide;
        logic [IDX_W-1:0]              in_idx;
        logic [IDX_W-1:0]              hit_idx;
        logic [IDX_W+SLOT_FIELD_W-1:0] hit_wide;
        logic [CNT_W:0]                next_base;
        logic [SECTOR_W+IDX_W-1:0]     prod;
        logic [SIDX_W-1:0]             sidx_inc;
        logic                          in_range;

        state_next    = state_reg;
        cmd_next      = cmd_reg;
        slot_in_next  = slot_in_reg;
        row_next      = row_reg;
        stat_next     = stat_reg;
        slot_out_next = slot_out_reg;
        sector_next   = sector_reg;
        offset_next   = offset_reg;
        xfer_next     = xfer_reg;
        last_next     = last_reg;
        sidx_next     = sidx_reg;

        bm_req.rd_row  = row_reg;
        bm_req.wr_en   = 1'b0;
        bm_req.wr_row  = row_reg;
        bm_req.wr_data = rd_word;

        in_wide  = (IDX_W + SLOT_FIELD_W)'(slot_in_reg);
        in_idx   = in_wide[IDX_W-1:0];
        in_range = (CNT_W'(slot_in_reg) < eff_count);
        hit_idx  = {row_reg, zf_idx};
        hit_wide = (IDX_W + SLOT_FIELD_W)'(hit_idx);
        next_base = ((CNT_W + 1)'(row_reg) + (CNT_W + 1)'(1)) << BIT_W;
        prod     = (SECTOR_W + IDX_W)'(hit_idx) * (SECTOR_W + IDX_W)'(SECTORS_PER_SLOT);
        sidx_inc = sidx_reg + SIDX_W'(1);

        command.ready = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                in_wide       = (IDX_W + SLOT_FIELD_W)'(command.slot_index);
                bm_req.rd_row = in_wide[IDX_W-1:BIT_W];
                if (command.valid)
                begin
                    cmd_next     = command.cmd;
                    slot_in_next = command.slot_index;
                    row_next     = '0;
                    unique case (command.cmd)
                        CMD_STORE:
                        begin
                            bm_req.rd_row = '0;
                            state_next    = S_SEARCH;
                        end
                        CMD_LOAD, CMD_FREE:
                        begin
                            state_next = S_CHECK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                // The read of the following word is issued while this one is examined.
                bm_req.rd_row = row_reg + ROW_W'(1);
                if (zf_found && (CNT_W'(hit_idx) < eff_count))
                begin
                    bm_req.wr_en   = 1'b1;
                    bm_req.wr_data = rd_word | (WORD_W'(1) << zf_idx);
                    stat_next      = STAT_OK;
                    slot_out_next  = hit_wide[SLOT_FIELD_W-1:0];
                    sector_next    = prod[SECTOR_W-1:0];
                    offset_next    = '0;
                    xfer_next      = 1'b1;
                    sidx_next      = '0;
                    last_next      = (SECTORS_PER_SLOT == 1);
                    state_next     = S_OUT;
                end
                else if (zf_found || (next_base >= (CNT_W + 1)'(eff_count)))
                begin
                    // Everything below the slot count is in use.
                    stat_next     = STAT_FULL;
                    slot_out_next = '0;
                    sector_next   = '0;
                    offset_next   = '0;
                    xfer_next     = 1'b0;
                    last_next     = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end

            S_CHECK:
            begin
                slot_out_next = slot_in_reg;
                offset_next   = '0;
                sidx_next     = '0;
                bm_req.wr_row = in_idx[IDX_W-1:BIT_W];
                state_next    = S_OUT;
                if (!in_range || !rd_word[in_idx[BIT_W-1:0]])
                begin
                    stat_next   = STAT_BAD;
                    sector_next = '0;
                    xfer_next   = 1'b0;
                    last_next   = 1'b1;
                end
                else
                begin
                    bm_req.wr_en   = 1'b1;
                    bm_req.wr_data = rd_word & ~(WORD_W'(1) << in_idx[BIT_W-1:0]);
                    stat_next      = STAT_OK;
                    hit_idx        = in_idx;
                    prod = (SECTOR_W + IDX_W)'(hit_idx) * (SECTOR_W + IDX_W)'(SECTORS_PER_SLOT);
                    if (cmd_reg == CMD_LOAD)
                    begin
                        sector_next = prod[SECTOR_W-1:0];
                        xfer_next   = 1'b1;
                        last_next   = (SECTORS_PER_SLOT == 1);
                    end
                    else
                    begin
                        sector_next = '0;
                        xfer_next   = 1'b0;
                        last_next   = 1'b1;
                    end
                end
            end

            S_OUT:
            begin
                if (result.ready)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sidx_next   = sidx_inc;
                        sector_next = sector_reg + SECTOR_W'(1);
                        offset_next = offset_reg + OFFSET_W'(SECTOR_BYTES);
                        last_next   = (sidx_inc == SIDX_W'(SECTORS_PER_SLOT - 1));
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result.valid          = (state_reg == S_OUT);
    assign result.status         = stat_reg;
    assign result.slot_out       = slot_out_reg;
    assign result.sector_number  = sector_reg;
    assign result.page_offset    = offset_reg;
    assign result.transfer_valid = xfer_reg;
    assign result.last           = last_reg;

    // A new command is never taken while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !command.ready)
    else $error("command accepted while a result is pending");

    // Sector transfers only come with an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.transfer_valid) |-> (result.status == STAT_OK))
    else $error("sector transfer reported with an error status");

    // An error or a free-only response is always the single, final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.transfer_valid) |-> result.last)
    else $error("non-transfer result not marked last");

    // The bitmap only changes on the cycle a store or a release is decided.
    assert property (@(posedge clk) disable iff (!rst_n)
        bm_req.wr_en |=> (state_reg == S_OUT))
    else $error("bitmap written outside a command decision");

endmodule
